FILE: rtl/vlrs_pkg.sv
// ----------------------------------------------------------------------------
// vlrs_pkg
// Shared constants, codes and types of the variable-length record stack.
// ----------------------------------------------------------------------------
package vlrs_pkg;

  localparam int CAPACITY     = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int MAX_OUT      = 64;

  localparam int ACT_W  = 3;
  localparam int DATA_W = 8;
  localparam int LEN_W  = 10;
  localparam int MAXL_W = 7;
  localparam int STAT_W = 2;
  localparam int FREE_W = 11;

  localparam int PTR_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(MAX_OUT + 1);
  localparam int HDR_W  = 8 * HEADER_BYTES;
  localparam int CMP_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
  localparam int LCMP_W = (HDR_W > PTR_W) ? HDR_W : PTR_W;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CHECK = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_ROOM  = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  record_len;
    logic              last_byte;
    logic [MAXL_W-1:0] max_len;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic              is_empty;
    logic [FREE_W-1:0] free_bytes;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic hdr_wr;
    logic hdr_rd;
    logic calc;
    logic byte_rd;
    logic byte_out;
    logic none_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic push_commit;
    logic pp_busy;
    logic hdr_wr_last;
    logic hdr_rd_done;
    logic n_zero;
    logic stream_done;
  } dp_stat_t;

endpackage

FILE: rtl/vlrs_ifs.sv
// ----------------------------------------------------------------------------
// vlrs request and response channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface vlrs_req_if;
  logic                        valid;
  logic                        ready;
  logic [vlrs_pkg::ACT_W-1:0]  action;
  logic [vlrs_pkg::DATA_W-1:0] data_byte;
  logic [vlrs_pkg::LEN_W-1:0]  record_len;
  logic                        last_byte;
  logic [vlrs_pkg::MAXL_W-1:0] max_len;

  modport source (output valid, action, data_byte, record_len, last_byte, max_len,
                  input ready);
  modport sink (input valid, action, data_byte, record_len, last_byte, max_len,
                output ready);
endinterface

interface vlrs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [vlrs_pkg::STAT_W-1:0] status;
  logic [vlrs_pkg::DATA_W-1:0] out_byte;
  logic                        byte_valid;
  logic                        last;
  logic                        is_empty;
  logic [vlrs_pkg::FREE_W-1:0] free_bytes;

  modport source (output valid, status, out_byte, byte_valid, last, is_empty, free_bytes,
                  input ready);
  modport sink (input valid, status, out_byte, byte_valid, last, is_empty, free_bytes,
                output ready);
endinterface

FILE: rtl/vlrs_ctrl.sv
// ----------------------------------------------------------------------------
// vlrs_ctrl
// Sequencer: takes requests, runs header writes, header reads and byte streams.
// ----------------------------------------------------------------------------
module vlrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  vlrs_pkg::dp_stat_t   stat,
  output vlrs_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_WR,
    S_HDR_RD,
    S_CALC,
    S_STREAM,
    S_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        req_ready  = stat.out_free;
        cmd.accept = req_valid && stat.out_free;
        if (cmd.accept) begin
          if (stat.push_commit) begin
            state_next = S_HDR_WR;
          end else if (stat.pp_busy) begin
            state_next = S_HDR_RD;
          end
        end
      end
      S_HDR_WR: begin
        cmd.hdr_wr = 1'b1;
        if (stat.hdr_wr_last) begin
          state_next = S_IDLE;
        end
      end
      S_HDR_RD: begin
        cmd.hdr_rd = 1'b1;
        if (stat.hdr_rd_done) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_STREAM;
      end
      S_STREAM: begin
        if (stat.out_free) begin
          if (stat.n_zero) begin
            cmd.none_out = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.byte_rd = 1'b1;
            state_next  = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        // output register is free here: it was free when the read went out
        cmd.byte_out = 1'b1;
        state_next   = stat.stream_done ? S_IDLE : S_STREAM;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/vlrs_dp.sv
// ----------------------------------------------------------------------------
// vlrs_dp
// Datapath: byte store, stack pointers, push tracking and result register.
// ----------------------------------------------------------------------------
module vlrs_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  vlrs_pkg::req_t       req,
  input  vlrs_pkg::ctrl_cmd_t  cmd,
  output vlrs_pkg::dp_stat_t   stat,
  output vlrs_pkg::rsp_t       rsp,
  output logic                 rsp_valid,
  input  logic                 rsp_ready
);

  localparam logic [vlrs_pkg::PTR_W-1:0] CAP_P = vlrs_pkg::PTR_W'(vlrs_pkg::CAPACITY);
  localparam logic [vlrs_pkg::PTR_W-1:0] HDR_P = vlrs_pkg::PTR_W'(vlrs_pkg::HEADER_BYTES);

  logic [vlrs_pkg::DATA_W-1:0] mem [vlrs_pkg::CAPACITY];

  logic [vlrs_pkg::PTR_W-1:0]  top;
  logic [vlrs_pkg::PTR_W-1:0]  write_cursor;
  logic                        push_active;
  logic                        push_rejected;
  logic [vlrs_pkg::LEN_W-1:0]  pending_length;
  logic [vlrs_pkg::CNT_W-1:0]  cnt;
  logic [vlrs_pkg::HDR_W-1:0]  len_acc;
  logic [vlrs_pkg::PTR_W-1:0]  start;
  logic [vlrs_pkg::PTR_W-1:0]  room;
  logic [vlrs_pkg::MAXL_W-1:0] max_c;
  logic [vlrs_pkg::CNT_W-1:0]  n;
  logic                        is_pop;
  logic [vlrs_pkg::DATA_W-1:0] rdata;
  logic                        rd_zero;

  logic                        is_push;
  logic                        is_pp;
  logic                        empty_now;
  logic                        fit_req;
  logic                        rej_eff;
  logic [vlrs_pkg::PTR_W-1:0]  cur_eff;
  logic [vlrs_pkg::LEN_W-1:0]  plen_eff;
  logic                        wr_byte;
  logic                        push_commit;
  logic                        pp_busy;
  logic [vlrs_pkg::PTR_W-1:0]  top_nx;
  logic [vlrs_pkg::STAT_W-1:0] status_imm;
  logic [vlrs_pkg::PTR_W-1:0]  start_nx;
  logic [vlrs_pkg::PTR_W-1:0]  lenc;
  logic [vlrs_pkg::DATA_W-1:0] rbyte;
  logic [vlrs_pkg::HDR_W-1:0]  plen_wide;

  logic                        we;
  logic [vlrs_pkg::PTR_W-1:0]  waddr;
  logic [vlrs_pkg::DATA_W-1:0] wdata;
  logic                        re;
  logic [vlrs_pkg::PTR_W-1:0]  raddr;
  logic                        load;
  logic                        out_free;

  assign is_push   = (req.action == vlrs_pkg::ACT_PUSH);
  assign is_pp     = (req.action == vlrs_pkg::ACT_POP) || (req.action == vlrs_pkg::ACT_PEEK);
  assign empty_now = (top >= CAP_P);
  assign fit_req   = (vlrs_pkg::CMP_W'(top) >=
                      vlrs_pkg::CMP_W'(req.record_len) +
                      vlrs_pkg::CMP_W'(vlrs_pkg::HEADER_BYTES));

  // first byte of a record decides room and data region
  assign rej_eff  = push_active ? push_rejected : !fit_req;
  assign cur_eff  = push_active ? write_cursor : (top - vlrs_pkg::PTR_W'(req.record_len));
  assign plen_eff = push_active ? pending_length : req.record_len;
  assign wr_byte  = !rej_eff && (cur_eff < top);

  assign push_commit = is_push && req.last_byte && !rej_eff;
  assign pp_busy     = is_pp && !empty_now;

  always_comb begin
    top_nx     = top;
    status_imm = vlrs_pkg::ST_OK;
    case (req.action)
      vlrs_pkg::ACT_PUSH: begin
        if (push_commit) begin
          top_nx = top - vlrs_pkg::PTR_W'(plen_eff) - HDR_P;
        end
        if (req.last_byte && rej_eff) begin
          status_imm = vlrs_pkg::ST_FULL;
        end
      end
      vlrs_pkg::ACT_POP, vlrs_pkg::ACT_PEEK: begin
        status_imm = vlrs_pkg::ST_EMPTY;
      end
      vlrs_pkg::ACT_CLEAR: begin
        top_nx = CAP_P;
      end
      vlrs_pkg::ACT_CHECK: begin
        status_imm = fit_req ? vlrs_pkg::ST_ROOM : vlrs_pkg::ST_FULL;
      end
      default: begin
        status_imm = vlrs_pkg::ST_OK;
      end
    endcase
  end

  // store write port: record bytes on request, header bytes afterwards
  assign plen_wide = vlrs_pkg::HDR_W'(pending_length) >> {cnt, 3'b000};

  always_comb begin
    we    = 1'b0;
    waddr = cur_eff;
    wdata = req.data_byte;
    if (cmd.accept && is_push && wr_byte) begin
      we = 1'b1;
    end else if (cmd.hdr_wr) begin
      waddr = top + vlrs_pkg::PTR_W'(cnt);
      wdata = plen_wide[vlrs_pkg::DATA_W-1:0];
      we    = (waddr < CAP_P);
    end
  end

  // store read port: header bytes most significant first, then record bytes
  always_comb begin
    if (cmd.hdr_rd) begin
      raddr = top + HDR_P - vlrs_pkg::PTR_W'(1) - vlrs_pkg::PTR_W'(cnt);
      re    = (cnt < vlrs_pkg::CNT_W'(vlrs_pkg::HEADER_BYTES));
    end else begin
      raddr = start + vlrs_pkg::PTR_W'(cnt);
      re    = cmd.byte_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[vlrs_pkg::IDX_W-1:0]] <= wdata;
    end
    if (re) begin
      rdata   <= mem[raddr[vlrs_pkg::IDX_W-1:0]];
      rd_zero <= (raddr >= CAP_P);
    end
  end

  assign rbyte = rd_zero ? '0 : rdata;

  assign start_nx = top + HDR_P;
  assign lenc     = (vlrs_pkg::LCMP_W'(len_acc) > vlrs_pkg::LCMP_W'(room)) ?
                    room : vlrs_pkg::PTR_W'(len_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      top            <= CAP_P;
      write_cursor   <= '0;
      push_active    <= 1'b0;
      push_rejected  <= 1'b0;
      pending_length <= '0;
      cnt            <= '0;
    end else begin
      if (cmd.accept) begin
        top <= top_nx;
        cnt <= '0;
        if (is_push) begin
          write_cursor   <= wr_byte ? (cur_eff + vlrs_pkg::PTR_W'(1)) : cur_eff;
          pending_length <= plen_eff;
          push_active    <= !req.last_byte;
          push_rejected  <= req.last_byte ? 1'b0 : rej_eff;
        end else begin
          push_active <= 1'b0;
        end
      end
      if (cmd.hdr_wr || cmd.hdr_rd || cmd.byte_rd) begin
        cnt <= cnt + vlrs_pkg::CNT_W'(1);
      end
      if (cmd.calc) begin
        cnt <= '0;
        if (is_pop) begin
          top <= start + lenc;
        end
      end
    end
  end

  // pop and peek working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      start  <= start_nx;
      room   <= (start_nx <= CAP_P) ? (CAP_P - start_nx) : '0;
      is_pop <= (req.action == vlrs_pkg::ACT_POP);
      max_c  <= (req.max_len > vlrs_pkg::MAXL_W'(vlrs_pkg::MAX_OUT)) ?
                vlrs_pkg::MAXL_W'(vlrs_pkg::MAX_OUT) : req.max_len;
    end
    if (cmd.hdr_rd && (cnt != '0)) begin
      len_acc <= (len_acc << 8) | vlrs_pkg::HDR_W'(rbyte);
    end
    if (cmd.calc) begin
      n <= (vlrs_pkg::CMP_W'(max_c) < vlrs_pkg::CMP_W'(lenc)) ?
           vlrs_pkg::CNT_W'(max_c) : vlrs_pkg::CNT_W'(lenc);
    end
  end

  // result register
  assign out_free = !rsp_valid || rsp_ready;
  assign load     = (cmd.accept && !pp_busy) || cmd.byte_out || cmd.none_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rsp.status     <= status_imm;
      rsp.out_byte   <= '0;
      rsp.byte_valid <= 1'b0;
      rsp.last       <= 1'b1;
      rsp.is_empty   <= (top_nx >= CAP_P);
      rsp.free_bytes <= vlrs_pkg::FREE_W'(top_nx);
    end else if (cmd.byte_out) begin
      rsp.status     <= vlrs_pkg::ST_OK;
      rsp.out_byte   <= rbyte;
      rsp.byte_valid <= 1'b1;
      rsp.last       <= (cnt == n);
      rsp.is_empty   <= empty_now;
      rsp.free_bytes <= vlrs_pkg::FREE_W'(top);
    end else if (cmd.none_out) begin
      rsp.status     <= vlrs_pkg::ST_OK;
      rsp.out_byte   <= '0;
      rsp.byte_valid <= 1'b0;
      rsp.last       <= 1'b1;
      rsp.is_empty   <= empty_now;
      rsp.free_bytes <= vlrs_pkg::FREE_W'(top);
    end
  end

  always_comb begin
    stat.out_free    = out_free;
    stat.push_commit = push_commit;
    stat.pp_busy     = pp_busy;
    stat.hdr_wr_last = (cnt == vlrs_pkg::CNT_W'(vlrs_pkg::HEADER_BYTES - 1));
    stat.hdr_rd_done = (cnt == vlrs_pkg::CNT_W'(vlrs_pkg::HEADER_BYTES));
    stat.n_zero      = (n == '0);
    stat.stream_done = (cnt == n);
  end

endmodule

FILE: rtl/variable_length_record_stack.sv
// push bytes, clear, check room and unknown actions: the result is registered as the request is taken
// final push byte of a stored record: the header bytes are then written before the next request is taken
// pop/peek: header read (non-empty stack only) and length check, then
//   each returned byte is read through the single store read port
// reset (rst, synchronous): stack empty, no push in progress; store not cleared
// ----------------------------------------------------------------------------
// variable_length_record_stack
// Stack of variable-length byte records in one downward-growing byte store.
// ----------------------------------------------------------------------------
module variable_length_record_stack (
  input  logic        clk,
  input  logic        rst,
  vlrs_req_if.sink    req,
  vlrs_rsp_if.source  rsp
);

  vlrs_pkg::req_t      req_data;
  vlrs_pkg::rsp_t      rsp_data;
  vlrs_pkg::ctrl_cmd_t cmd;
  vlrs_pkg::dp_stat_t  stat;
  logic                req_ready;
  logic                rsp_valid;

  always_comb begin
    req_data.action     = req.action;
    req_data.data_byte  = req.data_byte;
    req_data.record_len = req.record_len;
    req_data.last_byte  = req.last_byte;
    req_data.max_len    = req.max_len;
  end

  assign req.ready      = req_ready;
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_data.status;
  assign rsp.out_byte   = rsp_data.out_byte;
  assign rsp.byte_valid = rsp_data.byte_valid;
  assign rsp.last       = rsp_data.last;
  assign rsp.is_empty   = rsp_data.is_empty;
  assign rsp.free_bytes = rsp_data.free_bytes;

  vlrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vlrs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready)
  );

endmodule
